>>> rtl/tagged_word_bank_parser_top_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros shared by the bank parser modules.
// -----------------------------------------------------------------------------
`ifndef TAGGED_WORD_BANK_PARSER_TOP_MACROS_SVH
`define TAGGED_WORD_BANK_PARSER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TWBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define TWBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/twbp_pkg.sv
// -----------------------------------------------------------------------------
// twbp_pkg
// Types, codes and helpers of the tagged bank word parser.
// -----------------------------------------------------------------------------
package twbp_pkg;

  // Number of data words that follow a data header.
  localparam int unsigned DATA_WORDS   = 14;
  localparam logic [3:0]  DATA_WORDS_W = 4'(DATA_WORDS);
  localparam logic [4:0]  DATA_COUNT_W = 5'(DATA_WORDS);

  // Result queue geometry.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Control word types (bits 30..27).
  localparam logic [3:0] CTL_TRIG_NUM  = 4'd2;
  localparam logic [3:0] CTL_TRIG_TIME = 4'd3;
  localparam logic [3:0] CTL_DATA_HDR  = 4'd8;
  localparam logic [3:0] CTL_INVALID   = 4'd14;

  // Result kinds.
  localparam logic [2:0] KIND_TRIG_NUM   = 3'd0;
  localparam logic [2:0] KIND_TRIG_TIME  = 3'd1;
  localparam logic [2:0] KIND_DATA       = 3'd2;
  localparam logic [2:0] KIND_COUNT_ERR  = 3'd3;
  localparam logic [2:0] KIND_INVALID    = 3'd4;
  localparam logic [2:0] KIND_TRUNC_TIME = 3'd5;

  typedef struct packed {
    logic [31:0] word;
    logic        bank_last;
  } twbp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] value;
    logic [3:0]  data_index;
    logic        end_of_run;
  } twbp_out_t;

  // Results of one item handed from the decoder to the result queue.
  typedef struct packed {
    logic [1:0] num;
    twbp_out_t  res0;
    twbp_out_t  res1;
  } twbp_push_t;

  function automatic twbp_out_t mk_res(logic [2:0] kind, logic [47:0] value,
                                       logic [3:0] idx);
    twbp_out_t r;
    r.kind       = kind;
    r.value      = value;
    r.data_index = idx;
    r.end_of_run = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/tagged_word_bank_parser_top.sv
// -----------------------------------------------------------------------------
// tagged_word_bank_parser_top
// Bank word parser: control word decode, trigger time assembly, data records.
// -----------------------------------------------------------------------------
// One bank word is accepted per clock cycle while the queue has room and is
// decoded in the same cycle; its results (none, one or two) enter a four-entry
// result queue and appear on the output behind earlier results, one result
// per cycle while out_ready_i is high. A word with at most one result then
// sustains one word per cycle; one with two needs two output transfers. Input
// ready is held low only while the queue has fewer than two free entries.
// -----------------------------------------------------------------------------
module tagged_word_bank_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  twbp_pkg::twbp_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output twbp_pkg::twbp_out_t out_item_o
);
  import twbp_pkg::*;

  logic       accept;
  logic       space;
  twbp_push_t push;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  // Word decode and parser state.
  twbp_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push)
  );

  // Result queue toward the output channel.
  twbp_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/twbp_decode.sv
// -----------------------------------------------------------------------------
// twbp_decode
// Parser state and the combinational decode of one bank word into results.
// -----------------------------------------------------------------------------
`include "tagged_word_bank_parser_top_macros.svh"

module twbp_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  twbp_pkg::twbp_in_t  item_i,
  output twbp_pkg::twbp_push_t push_o
);
  import twbp_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TIME = 2'd1,
    MODE_DATA = 2'd2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [23:0] time_lo_q, time_lo_d;
  logic [3:0]  left_q, left_d;
  logic        seen_q, seen_d;

  logic [3:0]  ctl_type;
  logic [1:0]  num;
  twbp_out_t   res0, res1;

  assign ctl_type = item_i.word[30:27];

  // Decode the word, then apply the end-of-bank rules.
  always_comb begin
    mode_d    = mode_q;
    time_lo_d = time_lo_q;
    left_d    = left_q;
    seen_d    = seen_q;
    res0      = '0;
    res1      = '0;
    num       = 2'd0;

    case (mode_q)
      MODE_TIME: begin
        res0      = mk_res(KIND_TRIG_TIME, {item_i.word[23:0], time_lo_q}, 4'd0);
        num       = 2'd1;
        seen_d    = 1'b1;
        time_lo_d = '0;
        mode_d    = MODE_IDLE;
      end
      MODE_DATA: begin
        res0   = mk_res(KIND_DATA, {16'd0, item_i.word}, DATA_WORDS_W - left_q);
        num    = 2'd1;
        left_d = left_q - 4'd1;
        if (left_d == 4'd0) begin
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        if (item_i.word[31]) begin
          case (ctl_type)
            CTL_TRIG_NUM: begin
              res0 = mk_res(KIND_TRIG_NUM, {36'd0, item_i.word[11:0]}, 4'd0);
              num  = 2'd1;
            end
            CTL_TRIG_TIME: begin
              time_lo_d = item_i.word[23:0];
              mode_d    = MODE_TIME;
            end
            CTL_DATA_HDR: begin
              if (item_i.word[4:0] != DATA_COUNT_W) begin
                res0 = mk_res(KIND_COUNT_ERR, {43'd0, item_i.word[4:0]}, 4'd0);
                num  = 2'd1;
              end
              left_d = DATA_WORDS_W;
              mode_d = (DATA_WORDS_W != 4'd0) ? MODE_DATA : MODE_IDLE;
            end
            CTL_INVALID: begin
              res0 = mk_res(KIND_INVALID, 48'd0, 4'd0);
              num  = 2'd1;
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    // End of bank: flush a pending time, add a zero time if none was seen.
    if (item_i.bank_last) begin
      if (mode_d == MODE_TIME) begin
        res0   = mk_res(KIND_TRUNC_TIME, {24'd0, time_lo_d}, 4'd0);
        num    = 2'd1;
        seen_d = 1'b1;
      end
      if (!seen_d) begin
        if (num == 2'd0) begin
          res0 = mk_res(KIND_TRIG_TIME, 48'd0, 4'd0);
        end else begin
          res1 = mk_res(KIND_TRIG_TIME, 48'd0, 4'd0);
        end
        num = num + 2'd1;
      end
      mode_d    = MODE_IDLE;
      time_lo_d = '0;
      left_d    = '0;
      seen_d    = 1'b0;
    end

    // Mark the last result of this item.
    if (num == 2'd1) begin
      res0.end_of_run = 1'b1;
    end else if (num == 2'd2) begin
      res1.end_of_run = 1'b1;
    end
  end

  assign push_o.num  = num;
  assign push_o.res0 = res0;
  assign push_o.res1 = res1;

  // Parser state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      time_lo_q <= '0;
      left_q    <= '0;
      seen_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      time_lo_q <= time_lo_d;
      left_q    <= left_d;
      seen_q    <= seen_d;
    end
  end

  `TWBP_ASSERT(a_data_has_words, (mode_q == MODE_DATA) |-> (left_q != 4'd0), "data mode with no words left")
  `TWBP_ASSERT(a_last_clears, (accept_i && item_i.bank_last) |=> (mode_q == MODE_IDLE && !seen_q && left_q == 4'd0), "state not cleared after end of bank")
  `TWBP_ASSERT_NEVER(a_num_range, accept_i && push_o.num == 2'd3, "more than two results for one item")

endmodule

>>> rtl/twbp_res_queue.sv
// -----------------------------------------------------------------------------
// twbp_res_queue
// Small result queue: takes up to two results per cycle while it has room, hands out one while the output is ready.
// -----------------------------------------------------------------------------
`include "tagged_word_bank_parser_top_macros.svh"

module twbp_res_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  twbp_pkg::twbp_push_t push_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output twbp_pkg::twbp_out_t  out_item_o
);
  import twbp_pkg::*;

  twbp_out_t              mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0]   count_q, count_d;
  logic [RES_PTR_W-1:0]   wr_ptr_nx;
  logic [RES_CNT_W-1:0]   push_n;
  logic                   pop;

  // Room for the worst case of one item.
  assign space_o     = (count_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];

  assign pop       = out_valid_o && out_ready_i;
  assign push_n    = wr_en_i ? RES_CNT_W'(push_i.num) : '0;
  assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_n);
    rd_ptr_d = pop ? rd_ptr_q + RES_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + push_n - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (wr_en_i && push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  `TWBP_ASSERT(a_count_max, count_q <= RES_CNT_W'(RES_DEPTH), "result queue count out of range")
  `TWBP_ASSERT_NEVER(a_no_overflow, wr_en_i && !space_o, "write into a queue without room")
  `TWBP_ASSERT(a_empty_ptrs, (count_q == '0) |-> (rd_ptr_q == wr_ptr_q), "empty queue with pointers apart")

endmodule
